// ----- hdl/llhs_pkg.sv -----
// llhs_pkg: shared types and constants for the least-loaded heap selector
// holds the controller state type and the command/status bundles between
// controller and datapath; no dependencies
`default_nettype none

package llhs_pkg;

    // fixed field widths and the reset device count
    localparam int DEV_BITS          = 4;
    localparam int STATUS_BITS       = 2;
    localparam int CFG_BITS          = 5;
    localparam int PICK_BITS         = 64;
    localparam int S_TDATA_BITS      = 8;
    localparam int M_TDATA_BITS      = 8;
    localparam int NUM_DEVICES_RESET = 16;

    // request kinds carried on s_tuser
    localparam logic ACT_SELECT = 1'b0;
    localparam logic ACT_FREE   = 1'b1;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_IDLE  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEL_RD,
        ST_SEL_LOAD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_FR_CHK,
        ST_FR_SLOT,
        ST_FR_ENT,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;    // latch the accepted word
        logic rd_root;    // read heap slot 0
        logic load_root;  // take the root as the moving node
        logic rd_kids;    // read both children of the current slot
        logic swap_dn;    // move the chosen child up into the current slot
        logic put_mov;    // write the moving node at the current slot
        logic rd_slot;    // read the slot of the named device
        logic rd_ent;     // read the heap entry at that slot
        logic res_range;  // report index out of range
        logic res_idle;   // report free on idle device
        logic load_free;  // take the entry as moving node, one unit less
        logic rd_parent;  // read the parent of the current slot
        logic swap_up;    // move the parent down into the current slot
        logic out_load;   // hand the result to the output register
    } dp_cmd_t;

    typedef struct packed {
        logic leaf;       // current slot has no child in use
        logic dn_swap;    // chosen child is strictly lighter
        logic range_err;  // device index not below device count
        logic idle_dev;   // device has no outstanding work
        logic at_root;    // current slot is the root
        logic up_swap;    // moving node strictly lighter than parent
        logic out_free;   // output register can take a result
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/least_loaded_heap_selector.sv -----
// least_loaded_heap_selector: a select sifts its entry down the heap and a free sifts
// its entry up, 5 levels at most with 16 devices. one request in flight: a new word is
// accepted once the last result is handed to the output register, even while that
// result still waits in the output register. synchronous active-low reset, like a device count
// write, restores the identity order with zero workload and pick counts at once.
`default_nettype none

module least_loaded_heap_selector #(
    parameter int MAX_DEVICES   = 16,
    parameter int WORKLOAD_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [llhs_pkg::CFG_BITS-1:0]     cfg_data,   // device count
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [llhs_pkg::S_TDATA_BITS-1:0] s_tdata,    // [3:0] target device
    input  wire logic                              s_tuser,    // [0] action
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [llhs_pkg::M_TDATA_BITS-1:0]      m_tdata     // [3:0] chosen_device, [5:4] status
);
    import llhs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // the device count register is always ready to take a write
    assign cfg_ready = 1'b1;

    llhs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    llhs_datapath #(
        .MAX_DEVICES   (MAX_DEVICES),
        .WORKLOAD_BITS (WORKLOAD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ----- hdl/llhs_ctrl.sv -----
// llhs_ctrl: sequencing state machine for select and free requests
// depends on llhs_pkg for the state type and the command/status bundles
`default_nettype none

module llhs_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic                 s_tuser,   // [0] action
    input  wire llhs_pkg::dp_status_t status,
    output llhs_pkg::dp_cmd_t         cmd
);
    import llhs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == ACT_FREE) ? ST_FR_CHK : ST_SEL_RD;
                end
            end
            ST_SEL_RD:   state_next = ST_SEL_LOAD;
            ST_SEL_LOAD: state_next = ST_DN_RD;
            ST_DN_RD:    state_next = status.leaf ? ST_DONE : ST_DN_CMP;
            ST_DN_CMP:   state_next = status.dn_swap ? ST_DN_RD : ST_DONE;
            ST_FR_CHK:   state_next = status.range_err ? ST_DONE : ST_FR_SLOT;
            ST_FR_SLOT:  state_next = ST_FR_ENT;
            ST_FR_ENT:   state_next = status.idle_dev ? ST_DONE : ST_UP_RD;
            ST_UP_RD:    state_next = status.at_root ? ST_DONE : ST_UP_CMP;
            ST_UP_CMP:   state_next = status.up_swap ? ST_UP_RD : ST_DONE;
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_SEL_RD:   cmd.rd_root   = 1'b1;
            ST_SEL_LOAD: cmd.load_root = 1'b1;
            ST_DN_RD: begin
                cmd.put_mov = status.leaf;
                cmd.rd_kids = !status.leaf;
            end
            ST_DN_CMP: begin
                cmd.swap_dn = status.dn_swap;
                cmd.put_mov = !status.dn_swap;
            end
            ST_FR_CHK: begin
                cmd.res_range = status.range_err;
                cmd.rd_slot   = !status.range_err;
            end
            ST_FR_SLOT:  cmd.rd_ent = 1'b1;
            ST_FR_ENT: begin
                cmd.res_idle  = status.idle_dev;
                cmd.load_free = !status.idle_dev;
            end
            ST_UP_RD: begin
                cmd.put_mov   = status.at_root;
                cmd.rd_parent = !status.at_root;
            end
            ST_UP_CMP: begin
                cmd.swap_up = status.up_swap;
                cmd.put_mov = !status.up_swap;
            end
            ST_DONE:     cmd.out_load = status.out_free;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // an accepted word always starts a request sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> state_reg != ST_IDLE)
        else $error("llhs_ctrl: accepted word did not start a sequence");

    // at most one heap write per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.swap_dn, cmd.swap_up, cmd.put_mov}))
        else $error("llhs_ctrl: conflicting heap writes");
`endif

endmodule

`default_nettype wire

// ----- hdl/llhs_datapath.sv -----
// llhs_datapath: heap storage, sift datapath, device count and result register
// depends on llhs_pkg; driven by commands from llhs_ctrl
`default_nettype none

module llhs_datapath #(
    parameter int MAX_DEVICES   = 16,
    parameter int WORKLOAD_BITS = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    input  wire logic [llhs_pkg::CFG_BITS-1:0]        cfg_data,
    input  wire logic [llhs_pkg::S_TDATA_BITS-1:0]    s_tdata,  // [3:0] target device
    input  wire llhs_pkg::dp_cmd_t                    cmd,
    output llhs_pkg::dp_status_t                      status,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [llhs_pkg::M_TDATA_BITS-1:0]         m_tdata   // [3:0] chosen_device, [5:4] status
);
    import llhs_pkg::*;

    localparam int IW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int CW = $clog2(MAX_DEVICES + 1);
    localparam int XW = IW + 2;
    localparam int N_RESET = (NUM_DEVICES_RESET > MAX_DEVICES) ? MAX_DEVICES
                                                                : NUM_DEVICES_RESET;
    localparam logic [WORKLOAD_BITS-1:0] WL_MAX  = '1;
    localparam logic [PICK_BITS-1:0]     PK_ONES = '1;

    // heap and device-to-slot memories; entries without a valid bit read as reset values
    logic [IW-1:0]            heap_id_mem [MAX_DEVICES];
    logic [WORKLOAD_BITS-1:0] heap_wl_mem [MAX_DEVICES];
    logic [PICK_BITS-1:0]     heap_pk_mem [MAX_DEVICES];
    logic [IW-1:0]            slot_mem    [MAX_DEVICES];
    logic [MAX_DEVICES-1:0]   heap_vld_reg;
    logic [MAX_DEVICES-1:0]   pick_vld_reg;
    logic [MAX_DEVICES-1:0]   slot_vld_reg;

    logic [CW-1:0]            n_reg;
    logic [DEV_BITS-1:0]      dev_reg;
    logic [IW-1:0]            p_reg;
    logic [IW-1:0]            mov_id_reg;
    logic [WORKLOAD_BITS-1:0] mov_wl_reg;
    logic [PICK_BITS-1:0]     mov_pk_reg;
    logic                     kid_one_reg;
    logic [DEV_BITS-1:0]      res_dev_reg;
    logic [STATUS_BITS-1:0]   res_status_reg;
    logic                     out_valid_reg;
    logic [DEV_BITS-1:0]      out_dev_reg;
    logic [STATUS_BITS-1:0]   out_status_reg;

    // registered read ports
    logic [IW-1:0]            ra_addr_reg, rb_addr_reg;
    logic [IW-1:0]            ra_id_q, rb_id_q, slot_q;
    logic [WORKLOAD_BITS-1:0] ra_wl_q, rb_wl_q;
    logic [PICK_BITS-1:0]     ra_pk_q, rb_pk_q;
    logic                     ra_vld_q, ra_pvld_q, rb_vld_q, rb_pvld_q, slot_vld_q;

    logic [IW-1:0]            ra_addr, rb_addr, slot_raddr;
    logic [XW-1:0]            l_x, r_x;
    logic                     r_out;
    logic [IW-1:0]            parent;
    logic [IW-1:0]            free_slot;
    logic [CW-1:0]            cfg_n;

    // resolved entries
    logic [IW-1:0]            ea_id, eb_id, c_id, c_addr;
    logic [WORKLOAD_BITS-1:0] ea_wl, eb_wl, c_wl;
    logic [PICK_BITS-1:0]     ea_pk, eb_pk, c_pk, pk_inc;
    logic                     take_r;

    logic                     heap_we, slot_we;
    logic [IW-1:0]            heap_wa, slot_wa;
    logic [IW-1:0]            heap_wd_id;
    logic [WORKLOAD_BITS-1:0] heap_wd_wl;
    logic [PICK_BITS-1:0]     heap_wd_pk;

    assign l_x    = XW'({p_reg, 1'b1});
    assign r_x    = l_x + XW'(1);
    assign r_out  = 32'(r_x) >= 32'(n_reg);
    assign parent = IW'((p_reg - IW'(1)) >> 1);

    assign ea_id = ra_vld_q ? ra_id_q : ra_addr_reg;
    assign ea_wl = ra_vld_q ? ra_wl_q : '0;
    assign ea_pk = (ra_vld_q && ra_pvld_q) ? ra_pk_q : '0;
    assign eb_id = rb_vld_q ? rb_id_q : rb_addr_reg;
    assign eb_wl = rb_vld_q ? rb_wl_q : '0;
    assign eb_pk = (rb_vld_q && rb_pvld_q) ? rb_pk_q : '0;

    assign free_slot = slot_vld_q ? slot_q : IW'(dev_reg);

    // equal workloads: lower pick count wins, ties to the right child
    assign take_r = !kid_one_reg &&
                    ((eb_wl < ea_wl) || ((eb_wl == ea_wl) && !(ea_pk < eb_pk)));
    assign c_id   = take_r ? eb_id : ea_id;
    assign c_wl   = take_r ? eb_wl : ea_wl;
    assign c_pk   = take_r ? eb_pk : ea_pk;
    assign c_addr = take_r ? rb_addr_reg : ra_addr_reg;
    assign pk_inc = ea_pk + PICK_BITS'(1);

    always_comb begin
        if (cfg_data == '0) begin
            cfg_n = CW'(1);
        end else if (32'(cfg_data) > 32'(MAX_DEVICES)) begin
            cfg_n = CW'(MAX_DEVICES);
        end else begin
            cfg_n = CW'(cfg_data);
        end
    end

    always_comb begin
        status.leaf      = 32'(l_x) >= 32'(n_reg);
        status.dn_swap   = take_r ? (mov_wl_reg > eb_wl) : (mov_wl_reg > ea_wl);
        status.range_err = 32'(dev_reg) >= 32'(n_reg);
        status.idle_dev  = ea_wl == '0;
        status.at_root   = p_reg == '0;
        status.up_swap   = mov_wl_reg < ea_wl;
        status.out_free  = !out_valid_reg || m_tready;
    end

    // read address selection
    always_comb begin
        ra_addr = '0;
        if (cmd.rd_root) begin
            ra_addr = '0;
        end else if (cmd.rd_kids) begin
            ra_addr = IW'(l_x);
        end else if (cmd.rd_ent) begin
            ra_addr = free_slot;
        end else if (cmd.rd_parent) begin
            ra_addr = parent;
        end
        rb_addr    = r_out ? IW'(l_x) : IW'(r_x);
        slot_raddr = IW'(dev_reg);
    end

    // heap write port
    always_comb begin
        heap_we    = cmd.put_mov || cmd.swap_dn || cmd.swap_up;
        heap_wa    = p_reg;
        heap_wd_id = mov_id_reg;
        heap_wd_wl = mov_wl_reg;
        heap_wd_pk = mov_pk_reg;
        slot_we    = heap_we;
        slot_wa    = mov_id_reg;
        if (cmd.swap_dn) begin
            heap_wd_id = c_id;
            heap_wd_wl = c_wl;
            heap_wd_pk = c_pk;
            slot_wa    = c_id;
        end else if (cmd.swap_up) begin
            heap_wd_id = ea_id;
            heap_wd_wl = ea_wl;
            heap_wd_pk = ea_pk;
            slot_wa    = ea_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (heap_we) begin
            heap_id_mem[heap_wa] <= heap_wd_id;
            heap_wl_mem[heap_wa] <= heap_wd_wl;
            heap_pk_mem[heap_wa] <= heap_wd_pk;
        end
        if (slot_we) begin
            slot_mem[slot_wa] <= p_reg;
        end
        ra_addr_reg <= ra_addr;
        ra_id_q     <= heap_id_mem[ra_addr];
        ra_wl_q     <= heap_wl_mem[ra_addr];
        ra_pk_q     <= heap_pk_mem[ra_addr];
        ra_vld_q    <= heap_vld_reg[ra_addr];
        ra_pvld_q   <= pick_vld_reg[ra_addr];
        rb_addr_reg <= rb_addr;
        rb_id_q     <= heap_id_mem[rb_addr];
        rb_wl_q     <= heap_wl_mem[rb_addr];
        rb_pk_q     <= heap_pk_mem[rb_addr];
        rb_vld_q    <= heap_vld_reg[rb_addr];
        rb_pvld_q   <= pick_vld_reg[rb_addr];
        if (cmd.rd_slot) begin
            slot_q     <= slot_mem[slot_raddr];
            slot_vld_q <= slot_vld_reg[slot_raddr];
        end
    end

    // control state: device count, valid bits, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg         <= CW'(N_RESET);
            heap_vld_reg  <= '0;
            pick_vld_reg  <= '0;
            slot_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                n_reg        <= cfg_n;
                heap_vld_reg <= '0;
                pick_vld_reg <= '0;
                slot_vld_reg <= '0;
            end else begin
                if (heap_we) begin
                    heap_vld_reg[heap_wa] <= 1'b1;
                    pick_vld_reg[heap_wa] <= 1'b1;
                    slot_vld_reg[slot_wa] <= 1'b1;
                end
                // pick counts wrap together
                if (cmd.load_root && pk_inc == PK_ONES) begin
                    pick_vld_reg <= '0;
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dev_reg        <= s_tdata[DEV_BITS-1:0];
            res_dev_reg    <= s_tdata[DEV_BITS-1:0];
            res_status_reg <= STATUS_OK;
        end
        if (cmd.load_root) begin
            p_reg       <= '0;
            mov_id_reg  <= ea_id;
            res_dev_reg <= DEV_BITS'(ea_id);
            mov_wl_reg  <= (ea_wl != WL_MAX) ? ea_wl + WORKLOAD_BITS'(1) : ea_wl;
            mov_pk_reg  <= (pk_inc == PK_ONES) ? '0 : pk_inc;
        end
        if (cmd.rd_kids) begin
            kid_one_reg <= r_out;
        end
        if (cmd.swap_dn) begin
            p_reg <= c_addr;
        end
        if (cmd.swap_up) begin
            p_reg <= ra_addr_reg;
        end
        if (cmd.rd_ent) begin
            p_reg <= free_slot;
        end
        if (cmd.load_free) begin
            mov_id_reg <= ea_id;
            mov_wl_reg <= ea_wl - WORKLOAD_BITS'(1);
            mov_pk_reg <= ea_pk;
        end
        if (cmd.res_range) begin
            res_status_reg <= STATUS_RANGE;
        end
        if (cmd.res_idle) begin
            res_status_reg <= STATUS_IDLE;
        end
        if (cmd.out_load) begin
            out_dev_reg    <= res_dev_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_BITS'({out_status_reg, out_dev_reg});

`ifndef SYNTHESIS
    // device count stays within the supported range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(n_reg) >= 1) && (32'(n_reg) <= MAX_DEVICES))
        else $error("llhs_datapath: device count out of range");

    // heap writes only land on slots in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        heap_we |-> 32'(p_reg) < 32'(n_reg))
        else $error("llhs_datapath: heap write beyond device count");

    // a sift-down step always moves deeper into the heap
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap_dn |=> 32'(p_reg) > 32'($past(p_reg)))
        else $error("llhs_datapath: sift-down did not descend");

    // a result is never loaded over one that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("llhs_datapath: result register overwritten");
`endif

endmodule

`default_nettype wire
